@@ src/mrss_pkg.sv @@
// Shared types, constants and codes of the multi-rail stripe scheduler.
package mrss_pkg;

  localparam int MAX_RAILS   = 8;
  localparam int ALIGN_BYTES = 128;
  localparam int ALIGN_LOG2  = $clog2(ALIGN_BYTES);

  localparam int SIZE_W  = 32;
  localparam int RAIL_W  = 3;
  localparam int RAILS_W = 4;
  localparam int CNT_W   = 4;
  localparam int PROD_W  = SIZE_W + RAIL_W;
  localparam int LEN_W   = SIZE_W + 1;

  // Quotient of the aligned divide: ceil(size / align) needs LEN_W - ALIGN_LOG2 bits.
  localparam int QUO_W    = LEN_W - ALIGN_LOG2;
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = (QUO_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W    = DIV_CYC * DIV_STEP;
  localparam int DIVC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAIL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STRIPE = CFG_IDX_W'(1);

  localparam logic [RAILS_W-1:0] RAIL_COUNT_RST = RAILS_W'(1);
  localparam logic [SIZE_W-1:0]  MIN_STRIPE_RST = SIZE_W'(1048576);

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_CLASS,
    FR_PREP,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  // One classified request as it crosses from the front to the back.
  typedef struct packed {
    logic               err;
    logic [RAILS_W-1:0] rails;
    logic [RAIL_W-1:0]  rail0;
    logic [CNT_W-1:0]   stripes;
    logic [SIZE_W-1:0]  size;
    logic [LEN_W-1:0]   stripe_len;
  } desc_t;

endpackage

@@ src/multi_rail_stripe_scheduler_top.sv @@
// Top level of the multi-rail stripe scheduler: config registers, front, queue, back.
// Front steps: accept, stripe count, divide set-up, serial divide at 4 quotient bits a step,
//   queue write. The first stripe then passes the back's load and output register; after it, one
//   a cycle while out_stall is low. With its serial divider, the front takes a new request
//   only once the last is queued; the back's up to 8 stripes overlap the next request's divide.
// Reset: synchronous, active low; clears queue, start rail and handshake state, loads defaults.
module multi_rail_stripe_scheduler_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mrss_pkg::SIZE_W-1:0]        in_message_bytes,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mrss_pkg::RAIL_W-1:0]        out_rail_id,
  output logic [2:0]                         out_stripe_index,
  output logic [mrss_pkg::SIZE_W-1:0]        out_stripe_offset,
  output logic [mrss_pkg::SIZE_W-1:0]        out_stripe_bytes,
  output logic                               out_last,
  output logic                               out_error,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrss_pkg::SIZE_W-1:0]        cfg_wdata
);

  logic [mrss_pkg::RAILS_W-1:0] rail_count_r, rail_count_nxt;
  logic [mrss_pkg::SIZE_W-1:0]  min_stripe_r, min_stripe_nxt;

  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  mrss_pkg::desc_t push_desc;
  mrss_pkg::desc_t pop_desc;

  // Configuration writes are always taken; software writes only while idle.
  assign cfg_ready = 1'b1;

  always_comb begin
    rail_count_nxt = rail_count_r;
    min_stripe_nxt = min_stripe_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrss_pkg::CFG_RAIL_COUNT: rail_count_nxt = cfg_wdata[mrss_pkg::RAILS_W-1:0];
        mrss_pkg::CFG_MIN_STRIPE: min_stripe_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rail_count_r <= mrss_pkg::RAIL_COUNT_RST;
      min_stripe_r <= mrss_pkg::MIN_STRIPE_RST;
    end else begin
      rail_count_r <= rail_count_nxt;
      min_stripe_r <= min_stripe_nxt;
    end
  end

  // Front: classify each request, hold the round-robin start rail.
  mrss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .rail_count_i     (rail_count_r),
    .min_stripe_i     (min_stripe_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_message_bytes (in_message_bytes),
    .push_o           (push),
    .desc_o           (push_desc),
    .full_i           (full)
  );

  // Queue: lets the front divide the next request while the back still emits.
  mrss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .empty_o     (empty)
  );

  // Back: cut into stripes, advance through the output register.
  mrss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty_i           (empty),
    .pop_o             (pop),
    .desc_i            (pop_desc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rail_id       (out_rail_id),
    .out_stripe_index  (out_stripe_index),
    .out_stripe_offset (out_stripe_offset),
    .out_stripe_bytes  (out_stripe_bytes),
    .out_last          (out_last),
    .out_error         (out_error)
  );

endmodule

@@ src/mrss_fifo.sv @@
// Short register queue of classified requests between front and back.
module mrss_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  mrss_pkg::desc_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mrss_pkg::desc_t pop_data_o,
  output logic           empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrss_pkg::desc_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign empty_o    = (count_r == '0);
  assign full_o     = (count_r == CNT_W'(DEPTH));
  assign pop_data_o = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

@@ src/mrss_front.sv @@
// Front end: accept a request, count stripes, divide out the stripe length, queue it.
module mrss_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mrss_pkg::RAILS_W-1:0]    rail_count_i,
  input  logic [mrss_pkg::SIZE_W-1:0]     min_stripe_i,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrss_pkg::SIZE_W-1:0]     in_message_bytes,
  output logic                            push_o,
  output mrss_pkg::desc_t                 desc_o,
  input  logic                            full_i
);

  mrss_pkg::front_state_t state_r, state_nxt;

  logic [mrss_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [mrss_pkg::RAILS_W-1:0] rails_r, rails_nxt;
  logic [mrss_pkg::SIZE_W-1:0]  minsz_r, minsz_nxt;
  logic [mrss_pkg::RAIL_W-1:0]  cur0_r, cur0_nxt;
  logic [mrss_pkg::RAIL_W-1:0]  next_rail_r, next_rail_nxt;
  logic [mrss_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         err_r, err_nxt;
  logic [mrss_pkg::DIV_W-1:0]   num_r, num_nxt;
  logic [2:0]                   rem_r, rem_nxt;
  logic [mrss_pkg::DIVC_W-1:0]  divc_r, divc_nxt;

  logic [mrss_pkg::RAILS_W-1:0] rails_in;
  logic [mrss_pkg::CNT_W-1:0]   stripes_cnt;
  logic [mrss_pkg::PROD_W-1:0]  thr;
  logic [mrss_pkg::LEN_W-1:0]   up_sum;
  logic [mrss_pkg::QUO_W-1:0]   dividend;
  logic [mrss_pkg::DIV_W-1:0]   dn;
  logic [2:0]                   dr;
  logic [3:0]                   dt;
  logic [mrss_pkg::RAILS_W-1:0] rail_sum;

  // Reduce a stale start rail into range by repeated subtraction.
  function automatic logic [mrss_pkg::RAIL_W-1:0] rail_mod(
    input logic [mrss_pkg::RAIL_W-1:0]  a,
    input logic [mrss_pkg::RAILS_W-1:0] b
  );
    logic [mrss_pkg::RAILS_W-1:0] r;
    r = {1'b0, a};
    for (int i = 0; i < mrss_pkg::MAX_RAILS - 1; i++) begin
      if (r >= b) begin
        r = r - b;
      end
    end
    return r[mrss_pkg::RAIL_W-1:0];
  endfunction

  assign rails_in = (rail_count_i > mrss_pkg::RAILS_W'(mrss_pkg::MAX_RAILS)) ?
                    mrss_pkg::RAILS_W'(mrss_pkg::MAX_RAILS) : rail_count_i;

  // Stripe count: one plus the number of multiples k*min below the size, for k below the rail count.
  always_comb begin
    stripes_cnt = mrss_pkg::CNT_W'(1);
    thr         = '0;
    for (int k = 1; k < mrss_pkg::MAX_RAILS; k++) begin
      thr = mrss_pkg::PROD_W'(k) * mrss_pkg::PROD_W'(minsz_r);
      if ((mrss_pkg::RAILS_W'(k) < rails_r) && (mrss_pkg::PROD_W'(size_r) > thr)) begin
        stripes_cnt = stripes_cnt + mrss_pkg::CNT_W'(1);
      end
    end
  end

  // ceil(ceil(size / align) / stripes) as a floor divide of a biased dividend.
  assign up_sum   = {1'b0, size_r} + mrss_pkg::LEN_W'(mrss_pkg::ALIGN_BYTES - 1);
  assign dividend = up_sum[mrss_pkg::LEN_W-1:mrss_pkg::ALIGN_LOG2] +
                    mrss_pkg::QUO_W'(cnt_r - mrss_pkg::CNT_W'(1));

  // Restoring divide, DIV_STEP quotient bits a cycle.
  always_comb begin
    dn = num_r;
    dr = rem_r;
    dt = '0;
    for (int i = 0; i < mrss_pkg::DIV_STEP; i++) begin
      dt = {dr, dn[mrss_pkg::DIV_W-1]};
      dn = {dn[mrss_pkg::DIV_W-2:0], 1'b0};
      if (dt >= cnt_r) begin
        dt    = dt - cnt_r;
        dn[0] = 1'b1;
      end
      dr = dt[2:0];
    end
  end

  assign rail_sum = {1'b0, cur0_r} + cnt_r;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    rails_nxt     = rails_r;
    minsz_nxt     = minsz_r;
    cur0_nxt      = cur0_r;
    next_rail_nxt = next_rail_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    divc_nxt      = divc_r;
    push_o        = 1'b0;
    in_stall      = (state_r != mrss_pkg::FR_IDLE);
    unique case (state_r)
      mrss_pkg::FR_IDLE: begin
        if (in_valid) begin
          size_nxt  = in_message_bytes;
          rails_nxt = rails_in;
          minsz_nxt = (min_stripe_i == '0) ? mrss_pkg::SIZE_W'(1) : min_stripe_i;
          err_nxt   = (rail_count_i == '0);
          cnt_nxt   = mrss_pkg::CNT_W'(1);
          cur0_nxt  = (rail_count_i == '0) ? '0 : rail_mod(next_rail_r, rails_in);
          state_nxt = (rail_count_i == '0) ? mrss_pkg::FR_PUSH : mrss_pkg::FR_CLASS;
        end
      end
      mrss_pkg::FR_CLASS: begin
        cnt_nxt   = stripes_cnt;
        state_nxt = mrss_pkg::FR_PREP;
      end
      mrss_pkg::FR_PREP: begin
        num_nxt   = mrss_pkg::DIV_W'(dividend);
        rem_nxt   = '0;
        divc_nxt  = '0;
        state_nxt = mrss_pkg::FR_DIV;
      end
      mrss_pkg::FR_DIV: begin
        num_nxt  = dn;
        rem_nxt  = dr;
        divc_nxt = divc_r + mrss_pkg::DIVC_W'(1);
        if (divc_r == mrss_pkg::DIVC_W'(mrss_pkg::DIV_CYC - 1)) begin
          state_nxt = mrss_pkg::FR_PUSH;
        end
      end
      mrss_pkg::FR_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (!err_r) begin
            next_rail_nxt = (rail_sum >= rails_r) ?
                            mrss_pkg::RAIL_W'(rail_sum - rails_r) :
                            mrss_pkg::RAIL_W'(rail_sum);
          end
          state_nxt = mrss_pkg::FR_IDLE;
        end
      end
      default: state_nxt = mrss_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    desc_o            = '0;
    desc_o.err        = err_r;
    desc_o.rails      = rails_r;
    desc_o.rail0      = cur0_r;
    desc_o.stripes    = cnt_r;
    desc_o.size       = size_r;
    desc_o.stripe_len = mrss_pkg::LEN_W'({num_r[mrss_pkg::QUO_W-1:0],
                                          {mrss_pkg::ALIGN_LOG2{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrss_pkg::FR_IDLE;
      next_rail_r <= '0;
    end else begin
      state_r     <= state_nxt;
      next_rail_r <= next_rail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    rails_r <= rails_nxt;
    minsz_r <= minsz_nxt;
    cur0_r  <= cur0_nxt;
    cnt_r   <= cnt_nxt;
    err_r   <= err_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    divc_r  <= divc_nxt;
  end

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrss_pkg::FR_DIV) |-> (cnt_r != '0) && (cnt_r <= rails_r))
    else $error("stripe count out of range during divide");

  a_len_zero_iff_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrss_pkg::FR_PUSH && !err_r) |-> ((size_r == '0) == (num_r == '0)))
    else $error("stripe length disagrees with message size");

endmodule

@@ src/mrss_back.sv @@
// Back end: cut a queued request into stripes and present one result a cycle while out_stall is low.
module mrss_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           empty_i,
  output logic                           pop_o,
  input  mrss_pkg::desc_t                desc_i,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mrss_pkg::RAIL_W-1:0]    out_rail_id,
  output logic [2:0]                     out_stripe_index,
  output logic [mrss_pkg::SIZE_W-1:0]    out_stripe_offset,
  output logic [mrss_pkg::SIZE_W-1:0]    out_stripe_bytes,
  output logic                           out_last,
  output logic                           out_error
);

  logic                          busy_r, busy_nxt;
  mrss_pkg::desc_t               d_r, d_nxt;
  logic [2:0]                    k_r, k_nxt;
  logic [mrss_pkg::SIZE_W-1:0]   left_r, left_nxt;
  logic [mrss_pkg::SIZE_W-1:0]   offset_r, offset_nxt;
  logic [mrss_pkg::RAIL_W-1:0]   cur_r, cur_nxt;

  logic                          ov_r, ov_nxt;
  logic [mrss_pkg::RAIL_W-1:0]   rail_r, rail_nxt;
  logic [2:0]                    idx_r, idx_nxt;
  logic [mrss_pkg::SIZE_W-1:0]   off_r, off_nxt;
  logic [mrss_pkg::SIZE_W-1:0]   bytes_r, bytes_nxt;
  logic                          last_r, last_nxt;
  logic                          err_r, err_nxt;

  logic                          adv;
  logic                          emit;
  logic                          is_last;
  logic [mrss_pkg::SIZE_W-1:0]   len;
  logic [mrss_pkg::RAILS_W-1:0]  cur_inc;

  assign adv     = !ov_r || !out_stall;
  assign emit    = adv && busy_r;
  assign is_last = d_r.err || ((mrss_pkg::CNT_W'(k_r) + mrss_pkg::CNT_W'(1)) == d_r.stripes);
  assign len     = ({1'b0, left_r} < d_r.stripe_len) ? left_r :
                   d_r.stripe_len[mrss_pkg::SIZE_W-1:0];
  assign cur_inc = {1'b0, cur_r} + mrss_pkg::RAILS_W'(1);
  assign pop_o   = !empty_i && (!busy_r || (emit && is_last));

  always_comb begin
    busy_nxt   = busy_r;
    d_nxt      = d_r;
    k_nxt      = k_r;
    left_nxt   = left_r;
    offset_nxt = offset_r;
    cur_nxt    = cur_r;
    ov_nxt     = ov_r;
    rail_nxt   = rail_r;
    idx_nxt    = idx_r;
    off_nxt    = off_r;
    bytes_nxt  = bytes_r;
    last_nxt   = last_r;
    err_nxt    = err_r;
    if (adv) begin
      ov_nxt = busy_r;
    end
    if (emit) begin
      if (d_r.err) begin
        rail_nxt  = '0;
        idx_nxt   = '0;
        off_nxt   = '0;
        bytes_nxt = '0;
        last_nxt  = 1'b0;
        err_nxt   = 1'b1;
      end else begin
        rail_nxt  = cur_r;
        idx_nxt   = k_r;
        off_nxt   = offset_r;
        bytes_nxt = len;
        last_nxt  = is_last;
        err_nxt   = 1'b0;
      end
      k_nxt      = k_r + 3'd1;
      left_nxt   = left_r - len;
      offset_nxt = offset_r + len;
      cur_nxt    = (cur_inc == d_r.rails) ? '0 : mrss_pkg::RAIL_W'(cur_inc);
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    // Load the next request when idle, or behind the final stripe of the current one.
    if (pop_o) begin
      busy_nxt   = 1'b1;
      d_nxt      = desc_i;
      k_nxt      = '0;
      left_nxt   = desc_i.size;
      offset_nxt = '0;
      cur_nxt    = desc_i.rail0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    k_r      <= k_nxt;
    left_r   <= left_nxt;
    offset_r <= offset_nxt;
    cur_r    <= cur_nxt;
    rail_r   <= rail_nxt;
    idx_r    <= idx_nxt;
    off_r    <= off_nxt;
    bytes_r  <= bytes_nxt;
    last_r   <= last_nxt;
    err_r    <= err_nxt;
  end

  assign out_valid         = ov_r;
  assign out_rail_id       = rail_r;
  assign out_stripe_index  = idx_r;
  assign out_stripe_offset = off_r;
  assign out_stripe_bytes  = bytes_r;
  assign out_last          = last_r;
  assign out_error         = err_r;

  a_within_message: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !d_r.err) |->
      (({1'b0, offset_r} + {1'b0, len}) <= {1'b0, d_r.size}))
    else $error("stripe runs past the end of the message");

  a_rail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !d_r.err) |-> ({1'b0, cur_r} < d_r.rails))
    else $error("rail beyond the rails in use");

endmodule

@@ tb/tb_multi_rail_stripe_scheduler_top.sv @@
// Self-checking testbench of the multi-rail stripe scheduler top level.
`timescale 1ns / 1ps

module tb_multi_rail_stripe_scheduler_top;

  localparam int RAND_SETS     = 18;     // random configuration sets
  localparam int ITEMS_PER_SET = 22;     // requests per random set
  localparam int PRESSURE_SET  = 12;     // set that runs under the long receiver hold
  localparam int HOLD_CYCLES   = 400;    // length of that hold
  localparam int CYCLE_LIMIT   = 500000; // timeout, far above the slowest correct run

  // One expected stripe as the block should present it.
  typedef struct packed {
    logic [mrss_pkg::RAIL_W-1:0] rail;
    logic [2:0]                  idx;
    logic [mrss_pkg::SIZE_W-1:0] off;
    logic [mrss_pkg::SIZE_W-1:0] len;
    logic                        last;
    logic                        err;
  } stripe_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [mrss_pkg::SIZE_W-1:0]    in_message_bytes = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mrss_pkg::RAIL_W-1:0]    out_rail_id;
  logic [2:0]                     out_stripe_index;
  logic [mrss_pkg::SIZE_W-1:0]    out_stripe_offset;
  logic [mrss_pkg::SIZE_W-1:0]    out_stripe_bytes;
  logic                           out_last;
  logic                           out_error;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mrss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mrss_pkg::SIZE_W-1:0]    cfg_wdata = '0;

  // Predictor state: register copies and the round-robin start rail.
  logic [mrss_pkg::RAILS_W-1:0]   cur_rails = mrss_pkg::RAIL_COUNT_RST;
  logic [mrss_pkg::SIZE_W-1:0]    cur_min = mrss_pkg::MIN_STRIPE_RST;
  logic [mrss_pkg::RAIL_W-1:0]    rr_next = '0;

  logic [mrss_pkg::SIZE_W-1:0]    sizes_to_send[$];  // requests not yet offered
  stripe_t                        stripes_due[$];    // stripes predicted, not yet seen

  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  logic                 hold_go = 1'b0;
  int                   hold_cnt = 0;
  int                   fault_cnt = 0;
  int unsigned          cycle_cnt = 0;

  multi_rail_stripe_scheduler_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_message_bytes  (in_message_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rail_id       (out_rail_id),
    .out_stripe_index  (out_stripe_index),
    .out_stripe_offset (out_stripe_offset),
    .out_stripe_bytes  (out_stripe_bytes),
    .out_last          (out_last),
    .out_error         (out_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Cut one accepted request into stripes and queue them as expected results.
  // Work at 64 bits so the aligned stripe length may exceed 32 bits.
  task automatic predict_stripes(input logic [mrss_pkg::SIZE_W-1:0] msg);
    logic [63:0] size, rails, minsz, cnt, per, slen, left, off, cur, len;
    stripe_t     s;
    size = 64'(msg);
    if (cur_rails == 0) begin
      // no rails: a single error result, start rail untouched
      s = '0;
      s.err = 1'b1;
      stripes_due.push_back(s);
      return;
    end
    rails = (cur_rails > mrss_pkg::MAX_RAILS) ? 64'(mrss_pkg::MAX_RAILS) : 64'(cur_rails);
    minsz = (cur_min == 0) ? 64'd1 : 64'(cur_min);
    cnt = (size + minsz - 1) / minsz;
    if (cnt > rails) cnt = rails;
    if (cnt < 1) cnt = 1;
    // reduce a stale start rail left over from a larger rail count
    cur = 64'(rr_next) % rails;
    rr_next = mrss_pkg::RAIL_W'((cur + cnt) % rails);
    per = (size + cnt - 1) / cnt;
    slen = ((per + mrss_pkg::ALIGN_BYTES - 1) / mrss_pkg::ALIGN_BYTES) * mrss_pkg::ALIGN_BYTES;
    left = size;
    off = 0;
    for (int k = 0; k < cnt; k++) begin
      len = (left < slen) ? left : slen;
      s.rail = mrss_pkg::RAIL_W'(cur);
      s.idx  = 3'(k);
      s.off  = mrss_pkg::SIZE_W'(off);
      s.len  = mrss_pkg::SIZE_W'(len);
      s.last = (k + 1 == cnt);
      s.err  = 1'b0;
      stripes_due.push_back(s);
      off  = off + len;
      left = left - len;
      cur  = (cur + 1) % rails;
    end
  endtask

  // Request driver: predict on acceptance, then offer the next size or idle.
  // Valid only drops when no request is pending or the random idle hits, never
  // while a request is waiting to be taken.
  always @(posedge clk) begin : request_driver
    logic advance;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      advance = !in_valid;
      if (in_valid && !in_stall) begin
        predict_stripes(in_message_bytes);
        advance = 1'b1;
      end
      if (advance) begin
        if (sizes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid         <= 1'b1;
          in_message_bytes <= sizes_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted on its own so the random stall stays independent.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  task automatic check_field(input string fname,
                             input logic [mrss_pkg::SIZE_W-1:0] want,
                             input logic [mrss_pkg::SIZE_W-1:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, fname, want, got);
      fault_cnt++;
    end
  endtask

  // Stripe monitor: compare each accepted result with the oldest prediction,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin : stripe_monitor
    stripe_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stripes_due.size() == 0) begin
        $display("%0t unexpected result: expected none, actual rail %0h offset %0h bytes %0h",
                 $time, out_rail_id, out_stripe_offset, out_stripe_bytes);
        fault_cnt++;
      end else begin
        want = stripes_due.pop_front();
        check_field("rail_id",       32'(want.rail), 32'(out_rail_id));
        check_field("stripe_index",  32'(want.idx),  32'(out_stripe_index));
        check_field("stripe_offset", want.off,       out_stripe_offset);
        check_field("stripe_bytes",  want.len,       out_stripe_bytes);
        check_field("last",          32'(want.last), 32'(out_last));
        check_field("error",         32'(want.err),  32'(out_error));
      end
    end
    out_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Write one register and update the predictor's copy once it is taken.
  task automatic write_reg(input logic [mrss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mrss_pkg::SIZE_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == mrss_pkg::CFG_RAIL_COUNT) begin
      cur_rails = val[mrss_pkg::RAILS_W-1:0];
    end else begin
      cur_min = val;
    end
  endtask

  task automatic configure(input logic [mrss_pkg::RAILS_W-1:0] rails,
                           input logic [mrss_pkg::SIZE_W-1:0] minsz);
    write_reg(mrss_pkg::CFG_RAIL_COUNT, mrss_pkg::SIZE_W'(rails));
    write_reg(mrss_pkg::CFG_MIN_STRIPE, minsz);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Queue at the falling edge so the driver never races the push.
  task automatic queue_size(input logic [mrss_pkg::SIZE_W-1:0] sz);
    @(negedge clk);
    sizes_to_send.push_back(sz);
  endtask

  // Hold until every request is taken and every predicted stripe has arrived.
  task automatic drain();
    @(negedge clk);
    while (sizes_to_send.size() != 0 || in_valid || stripes_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [mrss_pkg::RAILS_W-1:0] pick_rails();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return mrss_pkg::RAILS_W'(1);
      2:       return mrss_pkg::RAILS_W'($urandom_range(9, 15));
      default: return mrss_pkg::RAILS_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [mrss_pkg::SIZE_W-1:0] pick_min();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom_range(1, 256);
      2:       return $urandom_range(257, 65536);
      3:       return $urandom;
      4:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom_range(1024, 1 << 22);
    endcase
  endfunction

  // Sizes biased towards stripe-count and alignment boundaries, with full-range noise.
  function automatic logic [mrss_pkg::SIZE_W-1:0] pick_size(
    input logic [mrss_pkg::SIZE_W-1:0] minsz
  );
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 300);
      1: return $urandom_range(0, 1 << 20);
      2, 3: return $urandom;
      4: begin
        w = 64'((minsz == 0) ? 1 : minsz) * $urandom_range(1, 9) + $urandom_range(0, 2);
        w = w - 1;
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
      end
      5: return $urandom >> $urandom_range(0, 31);
      6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom_range(0, 7) * mrss_pkg::ALIGN_BYTES + $urandom_range(0, 2);
    endcase
  endfunction

  initial begin : stimulus
    logic [mrss_pkg::SIZE_W-1:0] reset_sizes [5];
    logic [mrss_pkg::SIZE_W-1:0] wide_sizes [11];
    int unsigned pad;
    reset_sizes = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd128, 32'd129};
    wide_sizes  = '{32'd0, 32'd1, 32'd7, 32'd8, 32'd127, 32'd128,
                    32'd1023, 32'd1024, 32'd1025, 32'hFFFF_FFFF,
                    32'hFFFF_FF80};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(18, 68);

    // Reset values: one rail, 1 MiB minimum; the all-ones size needs a 33-bit length.
    foreach (reset_sizes[i]) queue_size(reset_sizes[i]);

    // Eight rails, one-byte minimum: empty message, tiny sizes and full spread.
    drain();
    configure(mrss_pkg::RAILS_W'(8), 32'd1);
    foreach (wide_sizes[i]) queue_size(wide_sizes[i]);

    // No rails: error results only, start rail kept.
    drain();
    configure('0, 32'd1);
    queue_size(32'd5);
    queue_size(32'hFFFF_FFFF);

    // Rail count above the maximum, and a zero minimum stripe.
    drain();
    configure(mrss_pkg::RAILS_W'(15), 32'd0);
    queue_size(32'd1000);
    queue_size(32'h8000_0000);

    // Stale counter: steer the start rail to 7, then drop to three rails.
    drain();
    configure(mrss_pkg::RAILS_W'(8), 32'd128);
    pad = (7 - rr_next) & 7;
    if (pad == 0) pad = 8;
    queue_size(pad * mrss_pkg::ALIGN_BYTES);
    drain();
    configure(mrss_pkg::RAILS_W'(3), 32'd1);
    queue_size(32'd1000);

    for (int p = 0; p < RAND_SETS; p++) begin
      drain();
      if (p == RAND_SETS / 3) set_idling(68, 18);
      if (p == PRESSURE_SET) set_idling(0, 0);
      if (p == 0) begin
        configure(mrss_pkg::RAILS_W'(8), 32'hFFFF_FFFF);
      end else if (p == PRESSURE_SET) begin
        configure(mrss_pkg::RAILS_W'(8), 32'd1);
      end else begin
        configure(pick_rails(), pick_min());
      end
      // Stop the receiver while requests keep coming so the block backs up.
      if (p == PRESSURE_SET) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      repeat (ITEMS_PER_SET) queue_size(pick_size(cur_min));
    end

    drain();
    // Let any stray stripe surface before the verdict.
    repeat (32) @(posedge clk);
    if (fault_cnt == 0 && stripes_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/mrss_pkg.sv
src/mrss_fifo.sv
src/mrss_front.sv
src/mrss_back.sv
src/multi_rail_stripe_scheduler_top.sv
tb/tb_multi_rail_stripe_scheduler_top.sv
